FILE: hw/rtl/tgc_pkg.sv
package tgc_pkg;

    // Default geometry of the coordinate and timestamp fields
    localparam int TGC_COORD_BITS = 12;
    localparam int TGC_TIME_BITS  = 32;

    // Configuration register widths and reset values
    localparam int TGC_THR_BITS  = 12;
    localparam int TGC_HOLD_BITS = 16;
    localparam int TGC_CFG_BITS  = 16;
    localparam int TGC_ADDR_BITS = 1;

    localparam logic [TGC_THR_BITS-1:0]  TGC_THR_RESET  = 12'd20;
    localparam logic [TGC_HOLD_BITS-1:0] TGC_HOLD_RESET = 16'd1000;

    // Configuration register indexes
    localparam logic [TGC_ADDR_BITS-1:0] REG_MOVE_THRESHOLD = 1'd0;
    localparam logic [TGC_ADDR_BITS-1:0] REG_HOLD_TIME_MS   = 1'd1;

    // Event kinds
    localparam logic [1:0] EV_PRESS   = 2'd0;
    localparam logic [1:0] EV_HOLD    = 2'd1;
    localparam logic [1:0] EV_DRAG    = 2'd2;
    localparam logic [1:0] EV_RELEASE = 2'd3;

    // Entries between front and back
    localparam int TGC_QUEUE_DEPTH = 2;

    // Control part of one queued poll result
    typedef struct packed {
        logic       has_hold;
        logic [1:0] kind;
    } tgc_cmd_t;

    localparam int TGC_CMD_BITS = $bits(tgc_cmd_t);

endpackage

FILE: hw/rtl/tgc_front.sv
module tgc_front
    import tgc_pkg::*;
#(
    parameter int COORD_BITS = TGC_COORD_BITS,
    parameter int TIME_BITS  = TGC_TIME_BITS,
    localparam int POS_BITS  = COORD_BITS + 1
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration writes
    input  logic                        cfg_we,
    input  logic [TGC_ADDR_BITS-1:0]    cfg_addr,
    input  logic [TGC_CFG_BITS-1:0]     cfg_wdata,
    // polls
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        touched,
    input  logic [COORD_BITS-1:0]       sample_x,
    input  logic [COORD_BITS-1:0]       sample_y,
    input  logic [TIME_BITS-1:0]        now_ms,
    // queue push side
    input  logic                        q_full,
    output logic                        push,
    output tgc_cmd_t                    push_cmd,
    output logic signed [POS_BITS-1:0]  push_pos_x,
    output logic signed [POS_BITS-1:0]  push_pos_y,
    output logic [COORD_BITS-1:0]       push_hold_x,
    output logic [COORD_BITS-1:0]       push_hold_y
);

    localparam int CMP_BITS = (COORD_BITS > TGC_THR_BITS) ? COORD_BITS : TGC_THR_BITS;

    logic [TGC_THR_BITS-1:0]  move_threshold_reg;
    logic [TGC_HOLD_BITS-1:0] hold_time_reg;

    logic                  in_contact_reg, in_contact_next;
    logic                  moved_or_held_reg, moved_or_held_next;
    logic [COORD_BITS-1:0] start_x_reg, start_x_next;
    logic [COORD_BITS-1:0] start_y_reg, start_y_next;
    logic [COORD_BITS-1:0] prev_x_reg, prev_x_next;
    logic [COORD_BITS-1:0] prev_y_reg, prev_y_next;
    logic [TIME_BITS-1:0]  start_time_reg, start_time_next;

    logic                  accept;
    logic [COORD_BITS-1:0] dist_x;
    logic [COORD_BITS-1:0] dist_y;
    logic                  moved_far;
    logic [TIME_BITS-1:0]  elapsed;
    logic                  hold_due;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Distance from the start point on each axis, and the strict threshold test
    assign dist_x = (sample_x > start_x_reg) ? sample_x - start_x_reg : start_x_reg - sample_x;
    assign dist_y = (sample_y > start_y_reg) ? sample_y - start_y_reg : start_y_reg - sample_y;
    assign moved_far = (CMP_BITS'(dist_x) > CMP_BITS'(move_threshold_reg))
                    || (CMP_BITS'(dist_y) > CMP_BITS'(move_threshold_reg));

    // Elapsed time with wrap, strict compare against the hold time
    assign elapsed  = now_ms - start_time_reg;
    assign hold_due = elapsed > TIME_BITS'(hold_time_reg);

    // Classify the poll and work out the next touch state
    always_comb
    begin
        in_contact_next    = in_contact_reg;
        moved_or_held_next = moved_or_held_reg;
        start_x_next       = start_x_reg;
        start_y_next       = start_y_reg;
        prev_x_next        = prev_x_reg;
        prev_y_next        = prev_y_reg;
        start_time_next    = start_time_reg;
        push               = 1'b0;
        push_cmd.has_hold  = 1'b0;
        push_cmd.kind      = EV_DRAG;
        push_pos_x         = POS_BITS'({1'b0, sample_x} - {1'b0, prev_x_reg});
        push_pos_y         = POS_BITS'({1'b0, sample_y} - {1'b0, prev_y_reg});
        push_hold_x        = start_x_reg;
        push_hold_y        = start_y_reg;
        if (accept)
        begin
            if (touched)
            begin
                push        = 1'b1;
                prev_x_next = sample_x;
                prev_y_next = sample_y;
                if (!in_contact_reg)
                begin
                    in_contact_next    = 1'b1;
                    moved_or_held_next = 1'b0;
                    start_x_next       = sample_x;
                    start_y_next       = sample_y;
                    start_time_next    = now_ms;
                    push_cmd.kind      = EV_PRESS;
                    push_pos_x         = {1'b0, sample_x};
                    push_pos_y         = {1'b0, sample_y};
                end
                else if (!moved_or_held_reg)
                begin
                    if (moved_far)
                    begin
                        moved_or_held_next = 1'b1;
                    end
                    else if (hold_due)
                    begin
                        moved_or_held_next = 1'b1;
                        push_cmd.has_hold  = 1'b1;
                    end
                end
            end
            else if (in_contact_reg)
            begin
                push            = 1'b1;
                in_contact_next = 1'b0;
                push_cmd.kind   = EV_RELEASE;
                push_pos_x      = {1'b0, prev_x_reg};
                push_pos_y      = {1'b0, prev_y_reg};
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            move_threshold_reg <= TGC_THR_RESET;
            hold_time_reg      <= TGC_HOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_MOVE_THRESHOLD: move_threshold_reg <= cfg_wdata[TGC_THR_BITS-1:0];
                REG_HOLD_TIME_MS:   hold_time_reg      <= cfg_wdata[TGC_HOLD_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // Touch state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_contact_reg    <= 1'b0;
            moved_or_held_reg <= 1'b0;
            start_x_reg       <= '0;
            start_y_reg       <= '0;
            prev_x_reg        <= '0;
            prev_y_reg        <= '0;
            start_time_reg    <= '0;
        end
        else
        begin
            in_contact_reg    <= in_contact_next;
            moved_or_held_reg <= moved_or_held_next;
            start_x_reg       <= start_x_next;
            start_y_reg       <= start_y_next;
            prev_x_reg        <= prev_x_next;
            prev_y_reg        <= prev_y_next;
            start_time_reg    <= start_time_next;
        end
    end

    // A press only starts a contact, a hold only rides with a drag
    a_press_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_cmd.kind == EV_PRESS) |-> !in_contact_reg)
        else $error("press issued during a contact");

    a_hold_with_drag: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_cmd.has_hold) |-> (push_cmd.kind == EV_DRAG && !moved_or_held_reg))
        else $error("hold issued outside an unmoved drag");

    a_release_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_cmd.kind == EV_RELEASE) |=> !in_contact_reg)
        else $error("contact still open after release");

endmodule

FILE: hw/rtl/tgc_queue.sv
module tgc_queue
    import tgc_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = TGC_QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] wdata,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output logic [DATA_W-1:0] rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rdata     = entries_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Advance pointers with wrap, track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: hw/rtl/tgc_back.sv
module tgc_back
    import tgc_pkg::*;
#(
    parameter int COORD_BITS = TGC_COORD_BITS,
    localparam int POS_BITS  = COORD_BITS + 1
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // queue pop side
    input  logic                        q_not_empty,
    output logic                        pop,
    input  tgc_cmd_t                    head_cmd,
    input  logic signed [POS_BITS-1:0]  head_pos_x,
    input  logic signed [POS_BITS-1:0]  head_pos_y,
    input  logic [COORD_BITS-1:0]       head_hold_x,
    input  logic [COORD_BITS-1:0]       head_hold_y,
    // events
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  event_kind,
    output logic signed [POS_BITS-1:0]  pos_x,
    output logic signed [POS_BITS-1:0]  pos_y,
    output logic                        last_of_run
);

    logic                       out_valid_reg, out_valid_next;
    logic                       hold_sent_reg, hold_sent_next;
    logic [1:0]                 kind_reg, kind_next;
    logic signed [POS_BITS-1:0] pos_x_reg, pos_x_next;
    logic signed [POS_BITS-1:0] pos_y_reg, pos_y_next;
    logic                       last_reg, last_next;
    logic                       load;

    assign load = !out_valid_reg || out_ready;

    // Expand the queue head into one or two events; hold goes first
    always_comb
    begin
        out_valid_next = out_valid_reg;
        hold_sent_next = hold_sent_reg;
        kind_next      = kind_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = q_not_empty;
            if (q_not_empty)
            begin
                if (head_cmd.has_hold && !hold_sent_reg)
                begin
                    hold_sent_next = 1'b1;
                    kind_next      = EV_HOLD;
                    pos_x_next     = {1'b0, head_hold_x};
                    pos_y_next     = {1'b0, head_hold_y};
                    last_next      = 1'b0;
                end
                else
                begin
                    pop            = 1'b1;
                    hold_sent_next = 1'b0;
                    kind_next      = head_cmd.kind;
                    pos_x_next     = head_pos_x;
                    pos_y_next     = head_pos_y;
                    last_next      = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            hold_sent_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            hold_sent_reg <= hold_sent_next;
        end
    end

    // Output payload, no reset
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        pos_x_reg <= pos_x_next;
        pos_y_reg <= pos_y_next;
        last_reg  <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign event_kind  = kind_reg;
    assign pos_x       = pos_x_reg;
    assign pos_y       = pos_y_reg;
    assign last_of_run = last_reg;

    // A hold is never last and is followed at once by its drag
    a_hold_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == EV_HOLD) |-> !last_reg)
        else $error("hold marked as last event of a poll");

    a_drag_after_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ready && kind_reg == EV_HOLD)
            |=> (out_valid_reg && kind_reg == EV_DRAG && last_reg))
        else $error("hold not followed by its drag");

endmodule

FILE: hw/rtl/touch_gesture_classifier.sv
// Channel   Direction  tdata (low bit up)                    tuser        tlast
// s_axis    in         sample_x, sample_y, now_ms, zero pad  touched      -
// m_axis    out        pos_x, pos_y, zero pad                event_kind   last_of_run
// cfg       in         cfg_wdata: register value             -            -
//
// A poll is classified in the cycle it transfers; its events pass through the
// queue, then the output register. A poll that causes hold plus drag yields two
// events, sent in turn by the single output register; others yield one or none.
// Reset clears the touch state and restores the threshold and hold time.
// A two-entry queue separates classification from output, so polls keep
// transferring while the output is stalled until the queue fills.
module touch_gesture_classifier
    import tgc_pkg::*;
#(
    parameter int COORD_BITS = TGC_COORD_BITS,
    parameter int TIME_BITS  = TGC_TIME_BITS,
    localparam int POS_BITS  = COORD_BITS + 1,
    localparam int IN_W      = ((2 * COORD_BITS + TIME_BITS + 7) / 8) * 8,
    localparam int OUT_W     = ((2 * POS_BITS + 7) / 8) * 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [TGC_ADDR_BITS-1:0]  cfg_addr,
    input  logic [TGC_CFG_BITS-1:0]   cfg_wdata,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_W-1:0]           s_tdata,   // sample_x, sample_y, now_ms, pad
    input  logic                      s_tuser,   // touched
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_W-1:0]          m_tdata,   // pos_x, pos_y, pad
    output logic [1:0]                m_tuser,   // event_kind
    output logic                      m_tlast    // last_of_run
);

    localparam int Q_W = TGC_CMD_BITS + 2 * POS_BITS + 2 * COORD_BITS;

    logic                       push;
    tgc_cmd_t                   push_cmd;
    logic signed [POS_BITS-1:0] push_pos_x;
    logic signed [POS_BITS-1:0] push_pos_y;
    logic [COORD_BITS-1:0]      push_hold_x;
    logic [COORD_BITS-1:0]      push_hold_y;
    logic                       q_full;
    logic                       q_not_empty;
    logic                       pop;
    logic [Q_W-1:0]             q_wdata;
    logic [Q_W-1:0]             q_rdata;
    tgc_cmd_t                   head_cmd;
    logic signed [POS_BITS-1:0] head_pos_x;
    logic signed [POS_BITS-1:0] head_pos_y;
    logic [COORD_BITS-1:0]      head_hold_x;
    logic [COORD_BITS-1:0]      head_hold_y;
    logic signed [POS_BITS-1:0] out_pos_x;
    logic signed [POS_BITS-1:0] out_pos_y;

    tgc_front #(
        .COORD_BITS (COORD_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .touched     (s_tuser),
        .sample_x    (s_tdata[COORD_BITS-1:0]),
        .sample_y    (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .now_ms      (s_tdata[2*COORD_BITS+TIME_BITS-1:2*COORD_BITS]),
        .q_full      (q_full),
        .push        (push),
        .push_cmd    (push_cmd),
        .push_pos_x  (push_pos_x),
        .push_pos_y  (push_pos_y),
        .push_hold_x (push_hold_x),
        .push_hold_y (push_hold_y)
    );

    assign q_wdata = {push_cmd, push_pos_x, push_pos_y, push_hold_x, push_hold_y};

    tgc_queue #(
        .DATA_W (Q_W),
        .DEPTH  (TGC_QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wdata     (q_wdata),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .rdata     (q_rdata)
    );

    assign {head_cmd, head_pos_x, head_pos_y, head_hold_x, head_hold_y} = q_rdata;

    tgc_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .pop         (pop),
        .head_cmd    (head_cmd),
        .head_pos_x  (head_pos_x),
        .head_pos_y  (head_pos_y),
        .head_hold_x (head_hold_x),
        .head_hold_y (head_hold_y),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .event_kind  (m_tuser),
        .pos_x       (out_pos_x),
        .pos_y       (out_pos_y),
        .last_of_run (m_tlast)
    );

    // Pack positions, pad with zeros
    assign m_tdata = OUT_W'({out_pos_y, out_pos_x});

endmodule
